// File: rtl/tabl_pkg.sv
// ----------------------------------------------------------------------------
// tabl_pkg: shared types and constants for the three-axis biquad low-pass
// Widths of the sample, result and coefficient words, register indexes,
// reset values of the configuration registers and the sequencer op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tabl_pkg;

  // fixed word layout
  localparam int NUM_AXES        = 3;
  localparam int RAW_W           = 16;
  localparam int OUT_W           = 20;
  localparam int COEF_W          = 32;
  localparam int SCALE_W         = 24;
  localparam int HIST_W          = 48;
  localparam int SUM_W           = 51;
  localparam int PROD_W          = HIST_W + COEF_W;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed-point alignment
  localparam int FF_SHIFT = 6;
  localparam int FB_SHIFT = 30;
  localparam int MG_SHIFT = 40;

  // multiplier scan length of the milli-g product and width of the scan counter
  localparam int MG_BITS = SCALE_W + 1;
  localparam int CNT_W   = $clog2(COEF_W);

  // saturation limits
  localparam logic [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FB_COEF_1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FB_COEF_2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MG_SCALE  = 3'd5;

  // register reset values
  localparam logic signed [COEF_W-1:0] FF_COEF_0_RST = 32'sd402621;
  localparam logic signed [COEF_W-1:0] FF_COEF_1_RST = 32'sd805253;
  localparam logic signed [COEF_W-1:0] FF_COEF_2_RST = 32'sd402621;
  localparam logic signed [COEF_W-1:0] FB_COEF_1_RST = 32'sd2087874645;
  localparam logic signed [COEF_W-1:0] FB_COEF_2_RST = -32'sd1015743327;
  localparam logic [SCALE_W-1:0]       MG_SCALE_RST  = 24'd1024016;

  // one product per op, in this order
  typedef enum logic [2:0] {
    OP_FF0,
    OP_FF1,
    OP_FF2,
    OP_FB1,
    OP_FB2,
    OP_MG
  } op_e;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filt_x_mg;
    logic signed [OUT_W-1:0] filt_y_mg;
    logic signed [OUT_W-1:0] filt_z_mg;
  } result_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] ff0;
    logic signed [COEF_W-1:0] ff1;
    logic signed [COEF_W-1:0] ff2;
    logic signed [COEF_W-1:0] fb1;
    logic signed [COEF_W-1:0] fb2;
    logic [SCALE_W-1:0]       mg_scale;
  } coef_t;

  // sequencer strobes to every lane
  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic acc;
    op_e  op;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/tabl_intf.sv
// ----------------------------------------------------------------------------
// tabl_intf: valid/ready channels of the three-axis biquad low-pass
// Sample channel carries one raw three-axis word, result channel one
// filtered milli-g word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tabl_in_if;
  import tabl_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tabl_out_if;
  import tabl_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/tabl_smul.sv
// ----------------------------------------------------------------------------
// tabl_smul: bit-serial signed multiplier
// Scans a left-aligned multiplier MSB first, one bit per clock while step_i
// is high, and adds the 48-bit multiplicand into a doubling accumulator. The
// first bit scanned is the sign bit and carries negative weight.
// ----------------------------------------------------------------------------
`default_nettype none

module tabl_smul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic                                step_i,
  input  logic signed [tabl_pkg::HIST_W-1:0]  a_i,
  input  logic        [tabl_pkg::COEF_W-1:0]  b_i,
  output logic signed [tabl_pkg::PROD_W-1:0]  prod_o
);
  import tabl_pkg::*;

  logic signed [HIST_W-1:0] a_q, a_d;
  logic        [COEF_W-1:0] b_q, b_d;
  logic signed [PROD_W-1:0] p_q, p_d;
  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] addend;
  logic signed [PROD_W-1:0] p_dbl;
  logic                     first_q, first_d;

  assign a_ext = {{(PROD_W-HIST_W){a_q[HIST_W-1]}}, a_q};
  assign p_dbl = first_q ? {PROD_W{1'b0}} : {p_q[PROD_W-2:0], 1'b0};

  // sign bit subtracts, the rest add
  always_comb begin
    addend = {PROD_W{1'b0}};
    if (b_q[COEF_W-1]) begin
      addend = first_q ? -a_ext : a_ext;
    end
  end

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    p_d     = p_q;
    first_d = first_q;
    if (load_i) begin
      a_d     = a_i;
      b_d     = b_i;
      p_d     = {PROD_W{1'b0}};
      first_d = 1'b1;
    end else if (step_i) begin
      b_d     = {b_q[COEF_W-2:0], 1'b0};
      p_d     = p_dbl + addend;
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else begin
      first_q <= first_d;
    end
  end

  // operand and accumulator shift registers
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign prod_o = p_q;

endmodule

`default_nettype wire

// File: rtl/tabl_lane.sv
// ----------------------------------------------------------------------------
// tabl_lane: one axis of the biquad low-pass
// Holds the input and output history of its axis, picks the operands of each
// product for the serial multiplier and folds the products into the Q24.24
// output, then scales it to saturated milli-g.
// ----------------------------------------------------------------------------
`default_nettype none

module tabl_lane #(
  parameter int SAMPLE_BITS = tabl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tabl_pkg::lane_ctl_t                ctl_i,
  input  tabl_pkg::coef_t                    coef_i,
  input  logic [SAMPLE_BITS-1:0]             raw_i,
  output logic signed [tabl_pkg::OUT_W-1:0]  mg_o
);
  import tabl_pkg::*;

  localparam int FB_W = PROD_W - FB_SHIFT;
  localparam int MG_W = PROD_W - MG_SHIFT;

  logic signed [SAMPLE_BITS-1:0] x0_q, x1_q, x2_q;
  logic signed [HIST_W-1:0]      y1_q, y2_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [HIST_W-1:0]      a_sel;
  logic        [COEF_W-1:0]      b_sel;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SUM_W-1:0]       prod_ff, prod_fb, sum_ff, sum_fb;
  logic        [SUM_W-HIST_W:0]  hist_top;
  logic signed [HIST_W-1:0]      y0_sat;
  logic        [MG_W-OUT_W:0]    mg_top;

  function automatic logic signed [HIST_W-1:0] coef_ext(input logic signed [COEF_W-1:0] c);
    return {{(HIST_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

  function automatic logic [COEF_W-1:0] x_align(input logic [SAMPLE_BITS-1:0] x);
    return {x, {(COEF_W-SAMPLE_BITS){1'b0}}};
  endfunction

  // operand select: coefficient times sample, output times coefficient or scale
  always_comb begin
    unique case (ctl_i.op)
      OP_FF0: begin
        a_sel = coef_ext(coef_i.ff0);
        b_sel = x_align(x0_q);
      end
      OP_FF1: begin
        a_sel = coef_ext(coef_i.ff1);
        b_sel = x_align(x1_q);
      end
      OP_FF2: begin
        a_sel = coef_ext(coef_i.ff2);
        b_sel = x_align(x2_q);
      end
      OP_FB1: begin
        a_sel = y1_q;
        b_sel = coef_i.fb1;
      end
      OP_FB2: begin
        a_sel = y2_q;
        b_sel = coef_i.fb2;
      end
      OP_MG: begin
        // newest output sits in y1 after the history shift
        a_sel = y1_q;
        b_sel = {1'b0, coef_i.mg_scale, {(COEF_W-MG_BITS){1'b0}}};
      end
      default: begin
        a_sel = {HIST_W{1'b0}};
        b_sel = {COEF_W{1'b0}};
      end
    endcase
  end

  tabl_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ctl_i.load),
    .step_i (ctl_i.step),
    .a_i    (a_sel),
    .b_i    (b_sel),
    .prod_o (prod)
  );

  // feed-forward products are exact, feedback products floored by 2^30
  assign prod_ff = prod[SUM_W-1:0];
  assign prod_fb = {{(SUM_W-FB_W){prod[PROD_W-1]}}, prod[PROD_W-1:FB_SHIFT]};
  assign sum_ff  = sum_q + prod_ff;
  assign sum_fb  = sum_q + prod_fb;

  // clamp new output to 48 bits
  assign hist_top = sum_fb[SUM_W-1:HIST_W-1];
  always_comb begin
    if ((&hist_top) || !(|hist_top)) begin
      y0_sat = sum_fb[HIST_W-1:0];
    end else begin
      y0_sat = sum_fb[SUM_W-1] ? HIST_MIN : HIST_MAX;
    end
  end

  // milli-g: floor by 2^40, clamp to 20 bits
  assign mg_top = prod[PROD_W-1:MG_SHIFT+OUT_W-1];
  always_comb begin
    if ((&mg_top) || !(|mg_top)) begin
      mg_o = prod[MG_SHIFT+OUT_W-1:MG_SHIFT];
    end else begin
      mg_o = prod[PROD_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  // history shifts once per word, after the last feedback product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctl_i.acc && (ctl_i.op == OP_FB2)) begin
      x1_q <= x0_q;
      x2_q <= x1_q;
      y1_q <= y0_sat;
      y2_q <= y1_q;
    end
  end

  // new sample and running sum
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      x0_q  <= raw_i;
      sum_q <= '0;
    end else if (ctl_i.acc) begin
      unique case (ctl_i.op)
        OP_FF0, OP_FF1: sum_q <= sum_ff;
        OP_FF2:         sum_q <= sum_ff >>> FF_SHIFT;
        OP_FB1:         sum_q <= sum_fb;
        default:        sum_q <= sum_q;
      endcase
    end
  end

`ifndef SYNTH
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.acc && (ctl_i.op == OP_FB2)) |=> (x1_q == $past(x0_q)) && (y2_q == $past(y1_q)))
    else $error("history did not shift after the last feedback product");
`endif

endmodule

`default_nettype wire

// File: rtl/three_axis_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// three_axis_biquad_lowpass: three-axis second-order low-pass with milli-g out
// Per-axis direct form I biquad on raw accelerometer words, Q24.24 history,
// scaled to saturated milli-g with 8 fraction bits.
// ----------------------------------------------------------------------------
// One word is in flight at a time: a new word is accepted only after the
// previous one has been through all six products. The bit-serial multiplier
// in each axis lane scans one multiplier bit per clock through six products:
// three of SAMPLE_BITS bits, two of 32 bits and one of 25 bits, each with a
// load state before and an accumulate state after its scan. The axes run
// side by side. The result register lets a new word be accepted while the
// previous result still waits; configuration writes take effect at once and
// belong between words.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_biquad_lowpass #(
  parameter int SAMPLE_BITS = tabl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tabl_in_if.sink                             sample_i,
  tabl_out_if.source                          result_o,
  input  logic                                cfg_we_i,
  input  logic [tabl_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tabl_pkg::COEF_W-1:0]         cfg_data_i
);
  import tabl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_ACC
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_data_q, out_data_d;
  coef_t             coef_q;
  lane_ctl_t         lane_ctl;
  logic              accept;
  logic              out_free;

  logic [SAMPLE_BITS-1:0]    raw [NUM_AXES];
  logic signed [OUT_W-1:0]   mg  [NUM_AXES];

  function automatic logic [CNT_W-1:0] scan_last(input op_e op);
    unique case (op)
      OP_FF0, OP_FF1, OP_FF2: return CNT_W'(SAMPLE_BITS - 1);
      OP_FB1, OP_FB2:         return CNT_W'(COEF_W - 1);
      OP_MG:                  return CNT_W'(MG_BITS - 1);
      default:                return CNT_W'(COEF_W - 1);
    endcase
  endfunction

  function automatic op_e op_next(input op_e op);
    unique case (op)
      OP_FF0:  return OP_FF1;
      OP_FF1:  return OP_FF2;
      OP_FF2:  return OP_FB1;
      OP_FB1:  return OP_FB2;
      OP_FB2:  return OP_MG;
      default: return OP_MG;
    endcase
  endfunction

  // handshakes
  assign accept         = sample_i.valid && sample_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.ff0      <= FF_COEF_0_RST;
      coef_q.ff1      <= FF_COEF_1_RST;
      coef_q.ff2      <= FF_COEF_2_RST;
      coef_q.fb1      <= FB_COEF_1_RST;
      coef_q.fb2      <= FB_COEF_2_RST;
      coef_q.mg_scale <= MG_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FF_COEF_0: coef_q.ff0      <= cfg_data_i;
        REG_FF_COEF_1: coef_q.ff1      <= cfg_data_i;
        REG_FF_COEF_2: coef_q.ff2      <= cfg_data_i;
        REG_FB_COEF_1: coef_q.fb1      <= cfg_data_i;
        REG_FB_COEF_2: coef_q.fb2      <= cfg_data_i;
        REG_MG_SCALE:  coef_q.mg_scale <= cfg_data_i[SCALE_W-1:0];
        default:       coef_q          <= coef_q;
      endcase
    end
  end

  // sequencer: load, scan, accumulate for each of the six products
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (result_o.valid && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOAD;
          op_d    = OP_FF0;
        end
      end
      ST_LOAD: begin
        cnt_d   = scan_last(op_q);
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == '0) begin
          state_d = ST_ACC;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_ACC: begin
        if (op_q == OP_MG) begin
          // wait here until the result register frees up
          if (out_free) begin
            out_valid_d          = 1'b1;
            out_data_d.filt_x_mg = mg[0];
            out_data_d.filt_y_mg = mg[1];
            out_data_d.filt_z_mg = mg[2];
            state_d              = ST_IDLE;
          end
        end else begin
          op_d    = op_next(op_q);
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_FF0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // lane strobes
  assign lane_ctl.capture = accept;
  assign lane_ctl.load    = (state_q == ST_LOAD);
  assign lane_ctl.step    = (state_q == ST_SCAN);
  assign lane_ctl.acc     = (state_q == ST_ACC);
  assign lane_ctl.op      = op_q;

  // only the low SAMPLE_BITS of each raw reading count
  assign raw[0] = sample_i.data.raw_x[SAMPLE_BITS-1:0];
  assign raw[1] = sample_i.data.raw_y[SAMPLE_BITS-1:0];
  assign raw[2] = sample_i.data.raw_z[SAMPLE_BITS-1:0];

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    tabl_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .coef_i (coef_q),
      .raw_i  (raw[g]),
      .mg_o   (mg[g])
    );
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOAD) && (op_q == OP_FF0))
    else $error("accepted word did not start the first product");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == ST_ACC) && (op_q == OP_MG)))
    else $error("result word raised outside the milli-g accumulate");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && (cnt_q == '0)) |=> (state_q == ST_ACC))
    else $error("scan did not end in accumulate");
`endif

endmodule

`default_nettype wire

// File: bench/three_axis_biquad_lowpass_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_axis_biquad_lowpass_test: self-checking bench for the three-axis biquad
// Drives raw three-axis words through the valid/ready channels and programs
// the coefficient registers between phases. A bit-exact predictor of the
// filter keeps its own history, and each milli-g word is checked against it.
// ----------------------------------------------------------------------------

module three_axis_biquad_lowpass_test;
  import tabl_pkg::*;

  localparam int WIDE          = 128;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int HOLD_CYCLES   = 900;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 200;
  localparam int SHOW_LIMIT    = 10;

  // indexes past the register file, writes there must be ignored
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic signed [WIDE-1:0] HIST_TOP = (128'sd1 <<< (HIST_W - 1)) - 128'sd1;
  localparam logic signed [WIDE-1:0] HIST_BOT = -(128'sd1 <<< (HIST_W - 1));
  localparam logic signed [WIDE-1:0] MG_TOP   = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
  localparam logic signed [WIDE-1:0] MG_BOT   = -(128'sd1 <<< (OUT_W - 1));

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_e;

  // --------------------------------------------------------------------------
  // Filter predictor: per-axis direct form I history, expected milli-g words
  // --------------------------------------------------------------------------
  class biquad_predictor;
    logic signed [COEF_W-1:0] ff0, ff1, ff2, fb1, fb2;
    logic [SCALE_W-1:0]       scale;
    logic signed [RAW_W-1:0]  xh1[NUM_AXES], xh2[NUM_AXES];
    logic signed [HIST_W-1:0] yh1[NUM_AXES], yh2[NUM_AXES];
    result_t                  pending_mg[$];
    int                       fault_count;
    int                       result_idx;

    function new();
      ff0   = FF_COEF_0_RST;
      ff1   = FF_COEF_1_RST;
      ff2   = FF_COEF_2_RST;
      fb1   = FB_COEF_1_RST;
      fb2   = FB_COEF_2_RST;
      scale = MG_SCALE_RST;
      for (int a = 0; a < NUM_AXES; a++) begin
        xh1[a] = '0;
        xh2[a] = '0;
        yh1[a] = '0;
        yh2[a] = '0;
      end
      fault_count = 0;
      result_idx  = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_FF_COEF_0: ff0 = data;
        REG_FF_COEF_1: ff1 = data;
        REG_FF_COEF_2: ff2 = data;
        REG_FB_COEF_1: fb1 = data;
        REG_FB_COEF_2: fb2 = data;
        REG_MG_SCALE:  scale = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted word: advance every axis and queue its milli-g result
    function void take_sample(sample_t w);
      logic signed [RAW_W-1:0] x0[NUM_AXES];
      logic signed [OUT_W-1:0] mg[NUM_AXES];
      logic signed [WIDE-1:0]  acc, mgw, sc;
      result_t                 r;
      int                      a;
      x0[0] = w.raw_x;
      x0[1] = w.raw_y;
      x0[2] = w.raw_z;
      sc = {{(WIDE - SCALE_W){1'b0}}, scale};
      for (a = 0; a < NUM_AXES; a++) begin
        // Q30 feed-forward sum down to Q24, feedback products floored from Q54
        acc = ((ff0 * x0[a] + ff1 * xh1[a] + ff2 * xh2[a]) >>> FF_SHIFT)
            + ((fb1 * yh1[a]) >>> FB_SHIFT) + ((fb2 * yh2[a]) >>> FB_SHIFT);
        if (acc > HIST_TOP) acc = HIST_TOP;
        else if (acc < HIST_BOT) acc = HIST_BOT;
        xh2[a] = xh1[a];
        xh1[a] = x0[a];
        yh2[a] = yh1[a];
        yh1[a] = acc[HIST_W-1:0];
        // Q24 times Q0.24 leaves Q48, keep 8 fraction bits
        mgw = (acc * sc) >>> MG_SHIFT;
        if (mgw > MG_TOP) mgw = MG_TOP;
        else if (mgw < MG_BOT) mgw = MG_BOT;
        mg[a] = mgw[OUT_W-1:0];
      end
      r.filt_x_mg = mg[0];
      r.filt_y_mg = mg[1];
      r.filt_z_mg = mg[2];
      pending_mg.push_back(r);
    endfunction

    function void flag(string field, logic signed [OUT_W-1:0] want,
                       logic signed [OUT_W-1:0] got);
      fault_count++;
      if (fault_count <= SHOW_LIMIT)
        $display("result %0d: %s expected %0d, got %0d", result_idx, field, want, got);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (pending_mg.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOW_LIMIT)
          $display("result %0d: unexpected word %0d %0d %0d", result_idx,
                   got.filt_x_mg, got.filt_y_mg, got.filt_z_mg);
      end else begin
        want = pending_mg.pop_front();
        if (got.filt_x_mg !== want.filt_x_mg) flag("filt_x_mg", want.filt_x_mg, got.filt_x_mg);
        if (got.filt_y_mg !== want.filt_y_mg) flag("filt_y_mg", want.filt_y_mg, got.filt_y_mg);
        if (got.filt_z_mg !== want.filt_z_mg) flag("filt_z_mg", want.filt_z_mg, got.filt_z_mg);
      end
      result_idx++;
    endfunction

    function int pending();
      return pending_mg.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [COEF_W-1:0]    cfg_data_i;

  tabl_in_if  sample_if();
  tabl_out_if result_if();

  biquad_predictor model;
  int              send_pct = 0;
  int              recv_pct = 0;
  int              hold_asks = 0;
  logic [RAW_W-1:0] last_raw[NUM_AXES];

  always #10 clk_i = ~clk_i;

  three_axis_biquad_lowpass uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk_i) begin : receiver
    int hold_left;
    int hold_seen;
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // watch both channels; a result is matched before a word of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) model.match_result(result_if.data);
      if (sample_if.valid && sample_if.ready) model.take_sample(sample_if.data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("three_axis_biquad_lowpass_test: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  task automatic set_pace(pace_e p);
    case (p)
      PACE_FULL:        begin send_pct = 0;  recv_pct = 0;  end
      PACE_SEND_GAPS:   begin send_pct = 61; recv_pct = 0;  end
      PACE_RECV_STALLS: begin send_pct = 0;  recv_pct = 61; end
      default:          begin send_pct = 7;  recv_pct = 7;  end
    endcase
  endtask

  // offer one word, returns right after the edge that accepts it
  task automatic send_word(sample_t w);
    if ($urandom_range(99) < send_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_pct);
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= w;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  task automatic send_raw(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y, logic [RAW_W-1:0] z);
    sample_t w;
    w.raw_x = x;
    w.raw_y = y;
    w.raw_z = z;
    last_raw[0] = x;
    last_raw[1] = y;
    last_raw[2] = z;
    send_word(w);
  endtask

  // drop valid so the last accepted word is queued, then wait for every
  // expected word and let the sequencer come to rest
  task automatic settle();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    model.write_reg(idx, data);
  endtask

  task automatic load_coefs(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                            logic [COEF_W-1:0] c2, logic [COEF_W-1:0] c3,
                            logic [COEF_W-1:0] c4, logic [COEF_W-1:0] sc);
    write_reg(REG_FF_COEF_0, c0);
    write_reg(REG_FF_COEF_1, c1);
    write_reg(REG_FF_COEF_2, c2);
    write_reg(REG_FB_COEF_1, c3);
    write_reg(REG_FB_COEF_2, c4);
    write_reg(REG_MG_SCALE, sc);
    if ($urandom_range(1)) write_reg(REG_UNUSED_LO, $urandom);
    else write_reg(REG_UNUSED_HI, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_reset_coefs();
    load_coefs(FF_COEF_0_RST, FF_COEF_1_RST, FF_COEF_2_RST, FB_COEF_1_RST,
               FB_COEF_2_RST, {8'hA5, MG_SCALE_RST});
  endtask

  // coefficient near a base value, at a rail, or anything at all
  function automatic logic [COEF_W-1:0] pick_coef(logic [COEF_W-1:0] base);
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return base + 32'($urandom_range(8191)) - 32'd4096;
      2:       return base;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // mostly full-range noise, some small values, rails and held steps
  function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] prev);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return RAW_W'($urandom);
      5, 6:          return RAW_W'($urandom_range(511)) - 16'd256;
      7: begin
        case ($urandom_range(4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default:       return prev;
    endcase
  endfunction

  task automatic run_phase(pace_e p, int count, bit drain_each);
    set_pace(p);
    for (int n = 0; n < count; n++) begin
      if (drain_each) settle();
      send_raw(pick_raw(last_raw[0]), pick_raw(last_raw[1]), pick_raw(last_raw[2]));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sample_if.valid <= 1'b0;
    sample_if.data  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    model = new();
    for (int a = 0; a < NUM_AXES; a++) last_raw[a] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: rails, steps and a full-scale reversal at reset coefficients
    set_pace(PACE_FULL);
    send_raw(16'h0000, 16'h0000, 16'h0000);
    repeat (4) send_raw(16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (4) send_raw(16'h8000, 16'h8000, 16'h8000);
    send_raw(16'h7FFF, 16'h8000, 16'h0000);
    send_raw(16'h8000, 16'h7FFF, 16'hFFFF);
    send_raw(16'h0001, 16'hFFFF, 16'h0001);
    send_raw(16'h5555, 16'hAAAA, 16'h00FF);
    send_raw(16'hAAAA, 16'h5555, 16'hFF00);
    repeat (2) begin
      send_raw(16'h7FFF, 16'h8000, 16'h7FFF);
      send_raw(16'h8000, 16'h7FFF, 16'h8000);
    end
    repeat (2) send_raw(16'h0000, 16'h0000, 16'h0000);

    // output stalled for a long stretch while words keep coming
    hold_asks++;
    run_phase(PACE_FULL, 150, 1'b0);
    run_phase(PACE_SEND_GAPS, 100, 1'b0);

    // all coefficients at the positive rail: unstable, history saturates
    settle();
    load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'hFFFF_FFFF);
    run_phase(PACE_RECV_STALLS, 80, 1'b0);

    // negative rail, zero scale
    settle();
    load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h0000_0000);
    run_phase(PACE_BOTH, 80, 1'b0);

    // unity pass-through with a random scale
    settle();
    load_coefs(32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0, $urandom);
    run_phase(PACE_FULL, 80, 1'b0);

    // back to reset values; first words wait for the pipe to empty
    settle();
    load_reset_coefs();
    run_phase(PACE_SEND_GAPS, 12, 1'b1);
    run_phase(PACE_SEND_GAPS, 88, 1'b0);

    // random coefficient sets under every pacing
    for (int k = 0; k < 4; k++) begin
      settle();
      load_coefs(pick_coef(FF_COEF_0_RST), pick_coef(FF_COEF_1_RST),
                 pick_coef(FF_COEF_2_RST), pick_coef(FB_COEF_1_RST),
                 pick_coef(FB_COEF_2_RST), $urandom);
      run_phase(pace_e'(k), 100, 1'b0);
    end

    // second hold-off under receiver stalls
    settle();
    load_reset_coefs();
    hold_asks++;
    run_phase(PACE_RECV_STALLS, 60, 1'b0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if ((model.fault_count == 0) && (model.pending() == 0)) begin
      $display("three_axis_biquad_lowpass_test: clean");
    end else begin
      $display("three_axis_biquad_lowpass_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tabl_pkg.sv
rtl/tabl_intf.sv
rtl/tabl_smul.sv
rtl/tabl_lane.sv
rtl/three_axis_biquad_lowpass.sv
bench/three_axis_biquad_lowpass_test.sv
